/* src/qke_pkg.sv */
// ----------------------------------------------------------------------------
// qke_pkg
// Shared types and constants for the quaternary Krawtchouk evaluator.
// ----------------------------------------------------------------------------
package qke_pkg;

	localparam int MaxLength = 20;
	localparam int NumCells  = MaxLength + 1;
	localparam int LenW      = 5;
	localparam int ValW      = 42;

	localparam logic [LenW-1:0] LenReset = LenW'(5);
	localparam logic [LenW-1:0] LenMax   = LenW'(MaxLength);

	typedef logic [LenW-1:0]        len_t;
	typedef logic signed [ValW-1:0] coef_t;

	// control broadcast to every cell of the coefficient chain
	typedef struct packed {
		logic load;
		logic step;
		logic triple;
	} qke_ctl_t;

endpackage

/* src/qke_cell.sv */
// ----------------------------------------------------------------------------
// qke_cell
// One coefficient of the running product polynomial; multiplies by
// (1 - z) or (1 + 3z) using the coefficient handed over by its neighbor.
// ----------------------------------------------------------------------------
module qke_cell (
	input  logic              clk,
	input  qke_pkg::qke_ctl_t ctl,
	input  logic              seed,
	input  qke_pkg::coef_t    prev,
	output qke_pkg::coef_t    coef
);

	qke_pkg::coef_t coef_q;
	qke_pkg::coef_t addend;

	// times (1 + 3z) adds 3*prev, times (1 - z) subtracts prev
	always_comb begin
		if (ctl.triple) begin
			addend = (prev <<< 1) + prev;
		end else begin
			addend = -prev;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			coef_q <= qke_pkg::coef_t'(seed);
		end else if (ctl.step) begin
			coef_q <= coef_q + addend;
		end
	end

	assign coef = coef_q;

endmodule

/* src/quaternary_krawtchouk_eval_top.sv */
// ----------------------------------------------------------------------------
// quaternary_krawtchouk_eval_top
// Evaluates K_j(x) for the quaternary Krawtchouk family of code length n.
// ----------------------------------------------------------------------------
// K_j(x) is the coefficient of z^j in (1 - z)^x * (1 + 3z)^(n - x). A row of
// 21 cells holds that polynomial's coefficients; on each multiply step each
// cell adds a multiple of its lower neighbor's coefficient, so one step
// multiplies the polynomial by one linear factor. An item is loaded, takes
// n multiply steps, and then moves the selected coefficient into the output
// register once that register is free or being read; input stays closed
// until then; n is code_length saturated at 20. The output register lets a
// new item start while the previous result waits. Weights above n give 0.
// ----------------------------------------------------------------------------
module quaternary_krawtchouk_eval_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [4:0]            code_length,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [4:0]            degree,
	input  logic [4:0]            weight,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [41:0]    value
);

	qke_pkg::len_t     len_q;
	qke_pkg::len_t     len_sat;
	qke_pkg::len_t     degree_q;
	qke_pkg::len_t     weight_q;
	qke_pkg::len_t     cnt_q;
	logic              busy_q;
	logic              out_valid_q;
	qke_pkg::coef_t    value_q;
	qke_pkg::qke_ctl_t ctl;
	qke_pkg::coef_t    coefs [qke_pkg::NumCells];
	qke_pkg::coef_t    pick;
	logic              in_xfer;
	logic              stepping;
	logic              finish;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~busy_q;
	assign in_xfer   = in_valid & in_ready;

	assign len_sat  = (len_q > qke_pkg::LenMax) ? qke_pkg::LenMax : len_q;
	assign stepping = busy_q & (cnt_q < len_sat);
	assign finish   = busy_q & (cnt_q == len_sat) & (~out_valid_q | out_ready);

	// first x steps multiply by (1 - z), the rest by (1 + 3z)
	assign ctl.load   = in_xfer;
	assign ctl.step   = stepping;
	assign ctl.triple = (cnt_q >= weight_q);

	for (genvar k = 0; k < qke_pkg::NumCells; k++) begin : g_cell
		if (k == 0) begin : g_first
			qke_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.seed (1'b1),
				.prev ('0),
				.coef (coefs[k])
			);
		end else begin : g_rest
			qke_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.seed (1'b0),
				.prev (coefs[k-1]),
				.coef (coefs[k])
			);
		end
	end

	// coefficients above n stay zero, so only out-of-range indexes and weights above n need a guard
	always_comb begin
		if (weight_q > len_sat || degree_q > qke_pkg::LenMax) begin
			pick = '0;
		end else begin
			pick = coefs[degree_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= qke_pkg::LenReset;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid & cfg_ready) begin
				len_q <= code_length;
			end
			if (in_xfer) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (stepping) begin
				cnt_q <= cnt_q + qke_pkg::LenW'(1);
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			degree_q <= degree;
			weight_q <= weight;
		end
		if (finish) begin
			value_q <= pick;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

/* src/qke_chk.sv */
// ----------------------------------------------------------------------------
// qke_chk
// Port-level checks for the Krawtchouk evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module qke_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [41:0] value
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result changed or dropped while stalled");

	// one item at a time: an input transfer closes the input side
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready right after a transfer");

	// ready only drops because of a transfer
	a_in_keep: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input ready dropped without a transfer");

	// no result can appear the cycle after an input transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind quaternary_krawtchouk_eval_top qke_chk u_qke_chk (.*);
